// File: rtl/core/ucb1_pkg.sv
// Package for the UCB1 arm index unit: sequencer states and fixed-point constants.
// Has no dependencies; the top level imports it.
`default_nettype none
package ucb1_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_LN_SQ,
    ST_LN_FRAC,
    ST_LN_INT,
    ST_DIV_C,
    ST_SQRT,
    ST_OUT
  } ucb1_state_e;

  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned CFG_W     = 14;
  localparam int unsigned VAC_W     = 3;
  localparam int unsigned A_W       = 16;
  localparam int unsigned B_W       = 19;
  localparam int unsigned Q_W       = 18;
  localparam int unsigned M_W       = 32;
  localparam int unsigned V_W       = B_W + FRAC_BITS;
  localparam int unsigned SQRT_STEPS = V_W / 2;

  localparam logic [M_W-1:0]   LN2_Q32   = 32'hB17217F7;
  localparam logic [CFG_W-1:0] CFG_RESET = 14'd11;
  localparam logic [VAC_W-1:0] VAC_MAX   = 3'd4;

endpackage
`default_nettype wire

// File: rtl/core/ucb1_arm_index_unit.sv
// UCB1 arm index unit: arm statistics and an iterative index datapath.
// Depends on ucb1_pkg for states and constants.
// The result is formed from the input transfer by two bit-serial divisions, 32
// squarings and 17 square-root steps.
// One item is processed at a time; input stall is high until the result is registered.
// Reset loads sum one, play count one, step count 11 and start total 11.
`default_nettype none
module ucb1_arm_index_unit import ucb1_pkg::*; #(
  parameter int unsigned COUNT_BITS = 14
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 action_i,
  input  wire logic                 played_i,
  input  wire logic [VAC_W-1:0]     vacant_channels_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [Q_W-1:0]            q_index_o
);

  localparam int unsigned CB    = COUNT_BITS;
  localparam int unsigned SUM_W = CB + FRAC_BITS;
  localparam int unsigned CW    = $clog2(SUM_W);
  localparam int unsigned KW    = $clog2(CB);
  localparam int unsigned SW    = (CB > CFG_W) ? CB : CFG_W;
  localparam int unsigned LN_W  = M_W + KW + 1;
  localparam logic [CB-1:0]    COUNT_MAX = {CB{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CB-1:0]    COUNT_ONE = CB'(1);

  ucb1_state_e state_q, state_d;

  logic [CFG_W-1:0] start_q;
  logic [SUM_W-1:0] sum_q;
  logic [CB-1:0]    play_q, step_q;
  logic             out_valid_q;
  logic [Q_W-1:0]   q_out_q;

  logic [CW-1:0]    cnt_q;
  logic [SUM_W-1:0] num_q;
  logic [CB-1:0]    rem_q;
  logic [A_W-1:0]   a_q;
  logic [M_W-1:0]   m_q, frac_q;
  logic [KW-1:0]    k_q;
  logic [2*M_W-1:0] prod_q;
  logic [V_W-1:0]   v_q, res_q, bit_q;

  logic             accept;
  logic             load_out;
  logic [CW-1:0]    cnt_last;
  logic             cnt_done;
  logic [M_W-1:0]   mul_a, mul_b;
  logic [2*M_W-1:0] prod;

  // Statistics update for the item being transferred.
  logic [15:0]      reward;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_new;
  logic [CB-1:0]    play_new, step_new, start_clamped;
  logic [SW-1:0]    start_ext;

  always_comb begin
    start_ext = SW'(start_q);
    if (start_ext > SW'(COUNT_MAX)) begin
      start_clamped = COUNT_MAX;
    end else begin
      start_clamped = start_ext[CB-1:0];
    end
    reward   = (vacant_channels_i <= VAC_MAX) ? {vacant_channels_i, 13'd0} : 16'd0;
    sum_add  = {1'b0, sum_q} + (SUM_W+1)'(reward);
    sum_new  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    play_new = (play_q == COUNT_MAX) ? play_q : play_q + COUNT_ONE;
    step_new = (step_q == COUNT_MAX) ? step_q : step_q + COUNT_ONE;
  end

  // Bit-serial restoring divider step, shared by both divisions.
  logic [CB-1:0] den;
  logic [CB:0]   rem_sh;
  logic          qbit;
  logic [CB-1:0] rem_next;
  logic [SUM_W-1:0] quo_next;

  always_comb begin
    den      = (play_q == '0) ? COUNT_ONE : play_q;
    rem_sh   = {rem_q, num_q[SUM_W-1]};
    qbit     = (rem_sh >= {1'b0, den});
    rem_next = qbit ? CB'(rem_sh - {1'b0, den}) : rem_sh[CB-1:0];
    quo_next = {num_q[SUM_W-2:0], qbit};
  end

  // Shared multiplier.
  assign prod = mul_a * mul_b;

  // Logarithm helpers.
  logic [KW-1:0]  k_new;
  logic [M_W-1:0] m_new;
  logic [M_W:0]   sq;
  logic [LN_W-1:0] ln_q32;
  logic [LN_W-18:0] ln_r;
  logic [B_W-1:0] b_val;

  always_comb begin
    k_new = '0;
    for (int i = 1; i < CB; i++) begin
      if (step_q[i]) begin
        k_new = KW'(i);
      end
    end
    m_new  = {{(M_W-CB){1'b0}}, step_q} << (5'd31 - 5'(k_new));
    sq     = prod[2*M_W-1:M_W-1];
    ln_q32 = LN_W'(prod[KW+M_W-1:0]) + LN_W'(prod_q[2*M_W-1:M_W]);
    ln_r   = ln_q32[LN_W-1:17];
    b_val  = (ln_r > (LN_W-17)'({B_W{1'b1}})) ? {B_W{1'b1}} : B_W'(ln_r);
  end

  // Square-root step.
  logic [V_W-1:0] trial;
  logic           take;
  always_comb begin
    trial = res_q + bit_q;
    take  = (v_q >= trial);
  end

  logic [Q_W:0]   q_sum;
  logic [Q_W-1:0] q_val;
  always_comb begin
    q_sum = (Q_W+1)'(a_q) + (Q_W+1)'(res_q[SQRT_STEPS-1:0]);
    q_val = q_sum[Q_W] ? {Q_W{1'b1}} : q_sum[Q_W-1:0];
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = ST_DIV_A;
      ST_DIV_A:   if (cnt_done) state_d = ST_LN_SQ;
      ST_LN_SQ:   if (cnt_done) state_d = ST_LN_FRAC;
      ST_LN_FRAC: state_d = ST_LN_INT;
      ST_LN_INT:  state_d = ST_DIV_C;
      ST_DIV_C:   if (cnt_done) state_d = ST_SQRT;
      ST_SQRT:    if (cnt_done) state_d = ST_OUT;
      ST_OUT:     if (load_out) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && (state_q == ST_IDLE);
    load_out   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
    mul_a      = m_q;
    mul_b      = m_q;
    cnt_last   = CW'(SUM_W - 1);
    unique case (state_q)
      ST_LN_SQ:   cnt_last = CW'(M_W - 1);
      ST_SQRT:    cnt_last = CW'(SQRT_STEPS - 1);
      ST_LN_FRAC: begin
        mul_a = frac_q;
        mul_b = LN2_Q32;
      end
      ST_LN_INT:  begin
        mul_a = M_W'(k_q);
        mul_b = LN2_Q32;
      end
      default: ;
    endcase
    cnt_done = (cnt_q == cnt_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= CFG_RESET;
      sum_q       <= SUM_W'(1) << FRAC_BITS;
      play_q      <= COUNT_ONE;
      step_q      <= CB'(CFG_RESET);
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (!action_i) begin
          sum_q  <= SUM_W'(1) << FRAC_BITS;
          play_q <= COUNT_ONE;
          step_q <= start_clamped;
        end else begin
          step_q <= step_new;
          if (played_i) begin
            sum_q  <= sum_new;
            play_q <= play_new;
          end
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept || cnt_done || state_q == ST_LN_INT) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    if (load_out) begin
      q_out_q <= q_val;
    end
    unique case (state_q)
      ST_IDLE: begin
        num_q <= (action_i && played_i) ? sum_new : (action_i ? sum_q : SUM_W'(1) << FRAC_BITS);
        rem_q <= '0;
      end
      ST_DIV_A: begin
        num_q <= quo_next;
        rem_q <= rem_next;
        if (cnt_done) begin
          a_q    <= (quo_next > SUM_W'({A_W{1'b1}})) ? {A_W{1'b1}} : A_W'(quo_next);
          m_q    <= m_new;
          k_q    <= k_new;
          frac_q <= '0;
        end
      end
      ST_LN_SQ: begin
        if (sq[M_W]) begin
          m_q    <= sq[M_W:1];
          frac_q <= {frac_q[M_W-2:0], 1'b1};
        end else begin
          m_q    <= sq[M_W-1:0];
          frac_q <= {frac_q[M_W-2:0], 1'b0};
        end
      end
      ST_LN_INT: begin
        num_q <= SUM_W'(b_val);
        rem_q <= '0;
      end
      ST_DIV_C: begin
        num_q <= quo_next;
        rem_q <= rem_next;
        if (cnt_done) begin
          v_q   <= {quo_next[B_W-1:0], {FRAC_BITS{1'b0}}};
          res_q <= '0;
          bit_q <= V_W'(1) << (V_W - 2);
        end
      end
      ST_SQRT: begin
        if (take) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign q_index_o   = q_out_q;

endmodule
`default_nettype wire
